>>> design/tcte_pkg.sv
// Shared types and constants for the text console teletype engine.
// Used by the controller, the datapath and the top level.
package tcte_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;

  localparam logic [7:0]  NEWLINE_CODE    = 8'h0A;
  localparam logic [7:0]  BLANK_CODE      = 8'h20;
  localparam logic [7:0]  UNDERSCORE_CODE = 8'h5F;
  localparam logic [15:0] CLEAR_CELL      = 16'h0F20;
  localparam logic [7:0]  RESET_ATTR      = 8'h07;

  // Fill value selects.
  localparam logic [1:0]  FILL_ZERO  = 2'd0;
  localparam logic [1:0]  FILL_CLEAR = 2'd1;
  localparam logic [1:0]  FILL_BLANK = 2'd2;

  typedef enum logic [2:0] {
    REQ_TELETYPE = 3'd0,
    REQ_WRITE    = 3'd1,
    REQ_CURSOR   = 3'd2,
    REQ_TOGGLE   = 3'd3,
    REQ_CLEAR    = 3'd4,
    REQ_ATTR     = 3'd5,
    REQ_RECOLOR  = 3'd6,
    REQ_READ     = 3'd7
  } req_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_code;
    logic [7:0] attr_value;
    logic [4:0] row_pos;
    logic [6:0] col_pos;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  cursor_row_out;
    logic [6:0]  cursor_col_out;
    logic [15:0] cell_data;
    logic        cursor_shown;
    logic        status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_EXEC, ST_RD_WAIT, ST_RMW, ST_SCROLL_RD, ST_SCROLL_WR,
    ST_FILL, ST_SWEEP_RD, ST_SWEEP_WR, ST_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take_in;     // capture input item
    logic rd_cursor;   // read cell under cursor
    logic rd_pos;      // read cell at requested position
    logic rd_addr;     // read cell at sweep address + COLUMNS
    logic rd_sweep;    // read cell at sweep address
    logic wr_tty;      // write teletype char at cursor, advance cursor
    logic wr_direct;   // direct write at position
    logic set_cursor;
    logic wr_toggle;   // write toggled glyph at cursor
    logic wr_scroll;   // write scrolled cell at sweep address
    logic wr_fill;     // write fill value at sweep address
    logic wr_recolor;  // write recolored cell at sweep address
    logic newline;     // advance row, column zero
    logic home;        // cursor to (0,0)
    logic set_attr;
    logic capture;     // latch read data for result
    logic sweep_clr;
    logic sweep_inc;
    logic [1:0] fill_sel;  // zero, clear cell or blank line
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic in_grid;
    logic is_newline;
    logic at_last_col;
    logic at_last_row;
    logic sweep_end;       // sweep at last cell
    logic scroll_end;      // sweep at last moved cell
  } sts_t;

endpackage

>>> design/tcte_ctrl.sv
// Controller state machine for the text console teletype engine.
// Depends on tcte_pkg.
module tcte_ctrl
  import tcte_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  output logic   out_valid,
  input  logic   out_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.wr_fill  = 1'b1;
        cmd.fill_sel = FILL_ZERO;
        cmd.sweep_inc = 1'b1;
        if (sts.sweep_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.sweep_clr = 1'b1;
        state_nxt = ST_OUT;
        case (sts.req)
          REQ_TELETYPE: begin
            if (sts.is_newline) begin
              cmd.newline = 1'b1;
              if (sts.at_last_row) begin
                state_nxt = ST_SCROLL_RD;
              end
            end else begin
              cmd.wr_tty = 1'b1;
              if (sts.at_last_col && sts.at_last_row) begin
                state_nxt = ST_SCROLL_RD;
              end
            end
          end
          REQ_WRITE: cmd.wr_direct = sts.in_grid;
          REQ_CURSOR: cmd.set_cursor = sts.in_grid;
          REQ_TOGGLE: begin
            cmd.rd_cursor = 1'b1;
            state_nxt = ST_RMW;
          end
          REQ_CLEAR: begin
            cmd.home = 1'b1;
            state_nxt = ST_FILL;
          end
          REQ_ATTR: cmd.set_attr = 1'b1;
          REQ_RECOLOR: begin
            cmd.set_attr = 1'b1;
            state_nxt = ST_SWEEP_RD;
          end
          REQ_READ: begin
            if (sts.in_grid) begin
              cmd.rd_pos = 1'b1;
              state_nxt = ST_RD_WAIT;
            end
          end
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_RD_WAIT: begin
        cmd.capture = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_RMW: begin
        cmd.wr_toggle = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_SCROLL_RD: begin
        cmd.rd_addr = 1'b1;
        state_nxt = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        cmd.wr_scroll = 1'b1;
        cmd.sweep_inc = 1'b1;
        state_nxt = sts.scroll_end ? ST_FILL : ST_SCROLL_RD;
      end
      ST_FILL: begin
        cmd.wr_fill  = 1'b1;
        cmd.fill_sel = (sts.req == REQ_CLEAR) ? FILL_CLEAR : FILL_BLANK;
        cmd.sweep_inc = 1'b1;
        if (sts.sweep_end) begin
          state_nxt = ST_OUT;
        end
      end
      ST_SWEEP_RD: begin
        cmd.rd_sweep = 1'b1;
        state_nxt = ST_SWEEP_WR;
      end
      ST_SWEEP_WR: begin
        cmd.wr_recolor = 1'b1;
        cmd.sweep_inc = 1'b1;
        state_nxt = sts.sweep_end ? ST_OUT : ST_SWEEP_RD;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> design/tcte_dpath.sv
// Datapath for the text console teletype engine: cell memory, cursor,
// attribute, sweep counter and result fields. Depends on tcte_pkg.
module tcte_dpath
  import tcte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t out_data
);

  logic [15:0] mem [CELLS];
  logic [15:0] rd_data_r;

  in_item_t        item_r;
  logic [ROW_W-1:0] crow_r;
  logic [COL_W-1:0] ccol_r;
  logic            drawn_r;
  logic [7:0]      attr_r;
  logic [ADDR_W-1:0] sweep_r;
  logic [ADDR_W-1:0] cur_base_r;  // crow_r * COLUMNS, tracked incrementally
  logic [15:0]     data_r;
  logic            status_r;

  logic            in_grid;
  logic [ADDR_W-1:0] pos_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic            rd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]     wr_data;
  logic            wr_en;
  logic [15:0]     fill_val;

  assign in_grid  = (32'(item_r.row_pos) < ROWS) && (32'(item_r.col_pos) < COLUMNS);
  assign pos_addr = ADDR_W'(32'(item_r.row_pos) * COLUMNS + 32'(item_r.col_pos));
  assign cur_addr = cur_base_r + ADDR_W'(ccol_r);

  // Status to controller.
  always_comb begin
    sts.req         = req_t'(item_r.req_type);
    sts.in_grid     = in_grid;
    sts.is_newline  = (item_r.char_code == NEWLINE_CODE);
    sts.at_last_col = (32'(ccol_r) == COLUMNS - 1);
    sts.at_last_row = (32'(crow_r) == ROWS - 1);
    sts.sweep_end   = (32'(sweep_r) == CELLS - 1);
    sts.scroll_end  = (32'(sweep_r) == CELLS - COLUMNS - 1);
  end

  // Select read address.
  always_comb begin
    rd_en   = cmd.rd_cursor | cmd.rd_pos | cmd.rd_addr | cmd.rd_sweep;
    rd_addr = sweep_r;
    if (cmd.rd_cursor) begin
      rd_addr = cur_addr;
    end else if (cmd.rd_pos) begin
      rd_addr = pos_addr;
    end else if (cmd.rd_addr) begin
      rd_addr = ADDR_W'(32'(sweep_r) + COLUMNS);
    end
  end

  // Select write address and data.
  always_comb begin
    case (cmd.fill_sel)
      FILL_ZERO:  fill_val = 16'h0000;
      FILL_CLEAR: fill_val = CLEAR_CELL;
      default:    fill_val = {attr_r, BLANK_CODE};
    endcase
    wr_en   = cmd.wr_tty | cmd.wr_direct | cmd.wr_toggle | cmd.wr_scroll
            | cmd.wr_fill | cmd.wr_recolor;
    wr_addr = sweep_r;
    wr_data = fill_val;
    if (cmd.wr_tty) begin
      wr_addr = cur_addr;
      wr_data = {attr_r, item_r.char_code};
    end else if (cmd.wr_direct) begin
      wr_addr = pos_addr;
      wr_data = {item_r.attr_value, item_r.char_code};
    end else if (cmd.wr_toggle) begin
      wr_addr = cur_addr;
      wr_data = {rd_data_r[15:8], drawn_r ? BLANK_CODE : UNDERSCORE_CODE};
    end else if (cmd.wr_scroll) begin
      wr_data = rd_data_r;
    end else if (cmd.wr_recolor) begin
      wr_data = {attr_r, rd_data_r[7:0]};
    end
  end

  // Cell memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      item_r <= in_data;
    end
  end

  // Cursor, attribute and sweep state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crow_r     <= '0;
      ccol_r     <= '0;
      cur_base_r <= '0;
      drawn_r    <= 1'b0;
      attr_r     <= RESET_ATTR;
      sweep_r    <= '0;
    end else begin
      if (cmd.sweep_clr) begin
        sweep_r <= '0;
      end else if (cmd.sweep_inc) begin
        sweep_r <= sts.sweep_end ? '0 : sweep_r + 1'b1;
      end
      if (cmd.set_attr) begin
        attr_r <= item_r.attr_value;
      end
      if (cmd.wr_toggle) begin
        drawn_r <= ~drawn_r;
      end
      if (cmd.home) begin
        crow_r     <= '0;
        ccol_r     <= '0;
        cur_base_r <= '0;
      end else if (cmd.set_cursor) begin
        crow_r     <= item_r.row_pos;
        ccol_r     <= item_r.col_pos;
        cur_base_r <= ADDR_W'(32'(item_r.row_pos) * COLUMNS);
      end else if (cmd.newline || (cmd.wr_tty && sts.at_last_col)) begin
        ccol_r <= '0;
        if (!sts.at_last_row) begin
          crow_r     <= crow_r + 1'b1;
          cur_base_r <= ADDR_W'(32'(cur_base_r) + COLUMNS);
        end
      end else if (cmd.wr_tty) begin
        ccol_r <= ccol_r + 1'b1;
      end
    end
  end

  // Result data and status.
  always_ff @(posedge clk) begin
    if (cmd.sweep_clr) begin
      data_r   <= '0;
      status_r <= ~in_grid && (sts.req == REQ_WRITE || sts.req == REQ_CURSOR
                               || sts.req == REQ_READ);
    end else if (cmd.capture) begin
      data_r <= rd_data_r;
    end
  end

  // Result fields come straight from state, which holds while a result waits.
  always_comb begin
    out_data.cursor_row_out = crow_r;
    out_data.cursor_col_out = ccol_r;
    out_data.cell_data      = data_r;
    out_data.cursor_shown   = drawn_r;
    out_data.status         = status_r;
  end

endmodule

>>> design/text_console_teletype_engine.sv
// Text console teletype engine: an 80x25 grid of 16-bit cells (attribute
// high byte, character low byte) kept in one single-port-write memory, with
// cursor, cursor-shown flag and current attribute. One request at a time;
// a scroll moves each cell up one row by a read and a write and then blanks
// the last row, clear fills every cell and recolor reads and rewrites every
// cell. After reset the memory is zeroed in a pass over all cells during
// which no request is accepted. Depends on tcte_pkg.
module text_console_teletype_engine
  import tcte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t cmd;
  sts_t sts;

  tcte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcte_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> dv/tb_text_console_teletype_engine.sv
// Testbench for the text console teletype engine: drives requests over the
// valid/ready input channel and checks every result against a local model.
// Depends on tcte_pkg and text_console_teletype_engine.
module tb_text_console_teletype_engine;
  import tcte_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  text_console_teletype_engine u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Console model state
  logic [15:0] grid [CELLS];
  logic [4:0]  crs_row;
  logic [6:0]  crs_col;
  logic        glyph_on;
  logic [7:0]  cur_attr;

  out_item_t   pending_results [$];
  int          mismatch_cnt;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic console_reset();
    for (int i = 0; i < CELLS; i++) grid[i] = '0;
    crs_row  = '0;
    crs_col  = '0;
    glyph_on = 1'b0;
    cur_attr = RESET_ATTR;
  endtask

  function automatic int cell_at(int r, int c);
    int idx;
    idx = r * COLUMNS + c;
    return (idx < CELLS) ? idx : 0;
  endfunction

  task automatic scroll_grid();
    for (int i = 0; i + COLUMNS < CELLS; i++) grid[i] = grid[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) grid[i] = {cur_attr, BLANK_CODE};
    crs_row = 5'(ROWS - 1);
  endtask

  task automatic advance_line();
    crs_col = '0;
    if (crs_row + 1 >= ROWS) scroll_grid();
    else crs_row = crs_row + 1'b1;
  endtask

  // Apply one request to the model, return the result it must produce
  task automatic console_apply(input in_item_t it, output out_item_t res);
    bit   in_grid;
    int   idx;
    logic [15:0] rd;
    logic        flag;
    in_grid = (it.row_pos < ROWS) && (it.col_pos < COLUMNS);
    rd   = '0;
    flag = 1'b0;
    case (req_t'(it.req_type))
      REQ_TELETYPE: begin
        if (it.char_code == NEWLINE_CODE) advance_line();
        else begin
          grid[cell_at(crs_row, crs_col)] = {cur_attr, it.char_code};
          if (crs_col + 1 >= COLUMNS) advance_line();
          else crs_col = crs_col + 1'b1;
        end
      end
      REQ_WRITE: begin
        if (in_grid) grid[cell_at(it.row_pos, it.col_pos)] = {it.attr_value, it.char_code};
        else flag = 1'b1;
      end
      REQ_CURSOR: begin
        if (in_grid) begin
          crs_row = it.row_pos;
          crs_col = it.col_pos;
        end else flag = 1'b1;
      end
      REQ_TOGGLE: begin
        idx = cell_at(crs_row, crs_col);
        grid[idx][7:0] = glyph_on ? BLANK_CODE : UNDERSCORE_CODE;
        glyph_on = ~glyph_on;
      end
      REQ_CLEAR: begin
        for (int i = 0; i < CELLS; i++) grid[i] = CLEAR_CELL;
        crs_row = '0;
        crs_col = '0;
      end
      REQ_ATTR: cur_attr = it.attr_value;
      REQ_RECOLOR: begin
        cur_attr = it.attr_value;
        for (int i = 0; i < CELLS; i++) grid[i][15:8] = it.attr_value;
      end
      default: begin
        if (in_grid) rd = grid[cell_at(it.row_pos, it.col_pos)];
        else flag = 1'b1;
      end
    endcase
    res.cursor_row_out = crs_row;
    res.cursor_col_out = crs_col;
    res.cell_data      = rd;
    res.cursor_shown   = glyph_on;
    res.status         = flag;
  endtask

  // Send one request: random gap, then hold valid until the transfer
  task automatic send_request(input in_item_t it);
    out_item_t res;
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    console_apply(it, res);
    pending_results.push_back(res);
  endtask

  function automatic in_item_t make_req(req_t op, logic [7:0] ch, logic [7:0] at,
                                        logic [4:0] r, logic [6:0] c);
    in_item_t it;
    it.req_type   = op;
    it.char_code  = ch;
    it.attr_value = at;
    it.row_pos    = r;
    it.col_pos    = c;
    return it;
  endfunction

  function automatic in_item_t rand_req(req_t op);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'($urandom));
    it.req_type = op;
    return it;
  endfunction

  // Check each result as it transfers
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.cursor_row_out !== want.cursor_row_out ||
            out_data.cursor_col_out !== want.cursor_col_out ||
            out_data.cell_data !== want.cell_data ||
            out_data.cursor_shown !== want.cursor_shown ||
            out_data.status !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected row %0d col %0d data %h shown %b st %b, got row %0d col %0d data %h shown %b st %b",
                     want.cursor_row_out, want.cursor_col_out, want.cell_data,
                     want.cursor_shown, want.status, out_data.cursor_row_out,
                     out_data.cursor_col_out, out_data.cell_data,
                     out_data.cursor_shown, out_data.status);
        end
      end
    end
  end

  // Result-side stall: a fresh wait count after each transfer
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      out_ready  <= 1'b0;
    end else if (out_valid && out_ready) begin
      stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      out_ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // Edges of the fields, every operation, out-of-grid cases
  task automatic test_directed();
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 5'd0, 7'd0));
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1)));
    send_request(make_req(REQ_WRITE, 8'hFF, 8'hFF, 5'(ROWS - 1), 7'(COLUMNS - 1)));
    send_request(make_req(REQ_WRITE, 8'h41, 8'h1E, 5'd31, 7'd127));
    send_request(make_req(REQ_WRITE, 8'h41, 8'h1E, 5'(ROWS), 7'd0));
    send_request(make_req(REQ_WRITE, 8'h41, 8'h1E, 5'd0, 7'(COLUMNS)));
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1)));
    send_request(make_req(REQ_READ, 8'hFF, 8'hFF, 5'd31, 7'd127));
    send_request(make_req(REQ_CURSOR, 8'h00, 8'h00, 5'd31, 7'd0));
    send_request(make_req(REQ_CURSOR, 8'h00, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1)));
    send_request(make_req(REQ_TELETYPE, 8'h58, 8'h00, 5'd0, 7'd0));   // wrap plus scroll
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 5'(ROWS - 2), 7'(COLUMNS - 1)));
    send_request(make_req(REQ_TELETYPE, NEWLINE_CODE, 8'h00, 5'd0, 7'd0));
    send_request(make_req(REQ_TOGGLE, 8'h00, 8'h00, 5'd0, 7'd0));
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 5'(ROWS - 1), 7'd0));
    send_request(make_req(REQ_TOGGLE, 8'h00, 8'h00, 5'd0, 7'd0));
    send_request(make_req(REQ_ATTR, 8'h00, 8'hA5, 5'd0, 7'd0));
    send_request(make_req(REQ_TELETYPE, 8'h00, 8'h00, 5'd0, 7'd0));
    send_request(make_req(REQ_RECOLOR, 8'h00, 8'h5A, 5'd0, 7'd0));
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 5'd3, 7'd3));
    send_request(make_req(REQ_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0));
    send_request(make_req(REQ_READ, 8'h00, 8'h00, 5'd12, 7'd40));
    send_request(make_req(REQ_RECOLOR, 8'h00, 8'h00, 5'd0, 7'd0));
    send_request(make_req(REQ_TELETYPE, 8'hFF, 8'h00, 5'd0, 7'd0));
  endtask

  // Mostly typing with reads and positioning; heavy ops kept rare
  task automatic test_random_mix(input int count);
    in_item_t it;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        it = rand_req(REQ_TELETYPE);
        if ($urandom_range(0, 9) == 0) it.char_code = NEWLINE_CODE;
      end else if (pick < 60) begin
        it = rand_req(REQ_READ);
        if ($urandom_range(0, 3) != 0) begin
          it.row_pos = 5'($urandom_range(0, ROWS - 1));
          it.col_pos = 7'($urandom_range(0, COLUMNS - 1));
        end
      end else if (pick < 70) begin
        it = rand_req(REQ_WRITE);
        if ($urandom_range(0, 3) != 0) begin
          it.row_pos = 5'($urandom_range(0, ROWS - 1));
          it.col_pos = 7'($urandom_range(0, COLUMNS - 1));
        end
      end else if (pick < 80) begin
        it = rand_req(REQ_CURSOR);
        if ($urandom_range(0, 3) != 0) begin
          it.row_pos = 5'($urandom_range(ROWS - 3, ROWS - 1));
          it.col_pos = 7'($urandom_range(COLUMNS - 4, COLUMNS - 1));
        end
      end else if (pick < 90) it = rand_req(REQ_TOGGLE);
      else if (pick < 96) it = rand_req(REQ_ATTR);
      else if (pick < 98) it = rand_req(REQ_RECOLOR);
      else it = rand_req(REQ_CLEAR);
      send_request(it);
    end
  endtask

  // Main sequence
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    mismatch_cnt = 0;
    console_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix(1300);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Run limit: room for every request to be a scroll
  initial begin
    #300000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
